/* rtl/sxfs_pkg.sv */
// ----------------------------------------------------------------------------
// sxfs_pkg
// Shared types and codes for the sprite XOR frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package sxfs_pkg;

  localparam int WORD_W    = 64;
  localparam int ADDR_W    = 7;
  localparam int ROW_W     = 6;
  localparam int ROW_OFS_W = 4;
  localparam int SLOTS     = 4;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_HIRES    = 1'b0,
    REG_DOUBLING = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic hires;
    logic dbl;
  } sxfs_cfg_t;

  typedef struct packed {
    cmd_t              kind;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic              two_rows;
    logic              wide;
    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [ADDR_W-1:0] word_index;
  } sxfs_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MODIFY,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/sxfs_front.sv */
// ----------------------------------------------------------------------------
// sxfs_front
// Accepts requests, wraps and clips the sprite row, builds per-word XOR masks.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfs_front #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 64,
  parameter int SPRITE_ROWS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sxfs_pkg::sxfs_cfg_t           cfg,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [7:0]                    in_start_x,
  input  wire logic [7:0]                    in_start_y,
  input  wire logic [7:0]                    in_row_bits,
  input  wire logic                          in_row_last,
  input  wire logic [sxfs_pkg::ADDR_W-1:0]   in_word_index,
  output logic                               q_push,
  output sxfs_pkg::sxfs_job_t                q_job,
  input  wire logic                          q_full
);

  localparam int WPR_MAX = (MAX_WIDTH + 63) / 64;

  logic [sxfs_pkg::ROW_OFS_W-1:0] row_offset_r;
  logic [sxfs_pkg::ROW_OFS_W-1:0] row_offset_nxt;

  logic [7:0]   width_s, height_s, lw, lh, limit, xpos, start, ysum;
  logic [10:0]  dx, dy, x0, x1, x2, x3, y0, y1, y2, y3, y4;
  logic         in_row;
  logic [7:0]   pat8;
  logic [15:0]  pat16, pat;
  logic [127:0] shifted, colmask, mask;
  logic [128:0] lim_one;
  sxfs_pkg::cmd_t cmd;

  assign cmd = sxfs_pkg::cmd_t'(in_cmd);

  always_comb begin
    width_s  = cfg.hires ? 8'(MAX_WIDTH) : 8'd64;
    height_s = cfg.hires ? 8'(MAX_HEIGHT) : 8'd32;
    lw       = cfg.dbl ? (width_s >> 1) : width_s;
    lh       = cfg.dbl ? (height_s >> 1) : height_s;
    limit    = cfg.dbl ? {lw[6:0], 1'b0} : lw;

    // start_x < 8*lw, start_y < 16*lh: restoring reduction
    dx = {3'b000, lw};
    x0 = {3'b000, in_start_x};
    x1 = (x0 >= (dx << 2)) ? x0 - (dx << 2) : x0;
    x2 = (x1 >= (dx << 1)) ? x1 - (dx << 1) : x1;
    x3 = (x2 >= dx) ? x2 - dx : x2;
    xpos = x3[7:0];

    dy = {3'b000, lh};
    y0 = {3'b000, in_start_y};
    y1 = (y0 >= (dy << 3)) ? y0 - (dy << 3) : y0;
    y2 = (y1 >= (dy << 2)) ? y1 - (dy << 2) : y1;
    y3 = (y2 >= (dy << 1)) ? y2 - (dy << 1) : y2;
    y4 = (y3 >= dy) ? y3 - dy : y3;
    ysum = {1'b0, y4[6:0]} + {4'b0000, row_offset_r};
    in_row = (ysum < lh);

    for (int k = 0; k < 8; k++) begin
      pat8[k]        = in_row_bits[7-k];
      pat16[2*k]     = in_row_bits[7-k];
      pat16[2*k + 1] = in_row_bits[7-k];
    end
    pat   = cfg.dbl ? pat16 : {8'h00, pat8};
    start = cfg.dbl ? {xpos[6:0], 1'b0} : xpos;

    shifted = {112'b0, pat} << start;
    lim_one = 129'(1) << limit;
    colmask = lim_one[127:0] - 128'd1;
    mask    = shifted & colmask & {128{in_row}};
  end

  always_comb begin
    q_job.kind       = cmd;
    q_job.last       = in_row_last;
    q_job.row        = cfg.dbl ? {ysum[4:0], 1'b0} : ysum[5:0];
    q_job.two_rows   = cfg.dbl;
    q_job.wide       = cfg.hires && (WPR_MAX > 1);
    q_job.mask_lo    = mask[63:0];
    q_job.mask_hi    = mask[127:64];
    q_job.word_index = in_word_index;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    row_offset_nxt = row_offset_r;
    if (q_push && (cmd == sxfs_pkg::CMD_DRAW)) begin
      if (in_row_last || (row_offset_r == sxfs_pkg::ROW_OFS_W'(SPRITE_ROWS - 1))) begin
        row_offset_nxt = '0;
      end else begin
        row_offset_nxt = row_offset_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_offset_r <= '0;
    end else begin
      row_offset_r <= row_offset_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/sxfs_queue.sv */
// ----------------------------------------------------------------------------
// sxfs_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sxfs_pkg::sxfs_job_t  din,
  output logic                      full,
  input  wire logic                 pop,
  output sxfs_pkg::sxfs_job_t       dout,
  output logic                      empty
);

  sxfs_pkg::sxfs_job_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/sxfs_back.sv */
// ----------------------------------------------------------------------------
// sxfs_back
// Executes jobs on the frame memory: read-modify-write per touched word,
// flash clear through per-word valid flags, word reads, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfs_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire sxfs_pkg::sxfs_job_t           q_job,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output logic                               out_collision,
  output logic [sxfs_pkg::WORD_W-1:0]        out_read_word
);

  localparam int WPR_MAX     = (MAX_WIDTH + 63) / 64;
  localparam int STORE_WORDS = WPR_MAX * MAX_HEIGHT;
  localparam int AW          = $clog2(STORE_WORDS);

  sxfs_pkg::back_state_t state_r, state_nxt;
  sxfs_pkg::sxfs_job_t   job_r;
  logic [sxfs_pkg::SLOTS-1:0] pend_r, pend_nxt, act;
  logic hit_r, hit_nxt, acc_r;
  logic out_valid_r, out_coll_r;
  logic [sxfs_pkg::WORD_W-1:0] out_word_r;

  logic [sxfs_pkg::WORD_W-1:0] mem [STORE_WORDS];
  logic [STORE_WORDS-1:0]      valid_r;
  logic [sxfs_pkg::WORD_W-1:0] rd_data_r;
  logic                        rd_hit_r;

  logic [1:0]                  slot;
  logic [sxfs_pkg::ROW_W-1:0]  slot_row;
  logic [sxfs_pkg::ADDR_W-1:0] slot_addr, rd_addr;
  logic [sxfs_pkg::WORD_W-1:0] slot_mask, old_word, new_word;
  logic rd_en, wr_en, clr_all, load_out, out_free, rd_inrange;

  // lowest pending slot: bit0 = word in row, bit1 = second row
  always_comb begin
    if (pend_r[0])      slot = 2'd0;
    else if (pend_r[1]) slot = 2'd1;
    else if (pend_r[2]) slot = 2'd2;
    else                slot = 2'd3;
  end

  always_comb begin
    slot_row  = job_r.row + sxfs_pkg::ROW_W'(slot[1]);
    slot_addr = job_r.wide ? {slot_row, slot[0]} : {1'b0, slot_row};
    slot_mask = slot[0] ? job_r.mask_hi : job_r.mask_lo;
    old_word  = rd_hit_r ? rd_data_r : '0;
    new_word  = old_word ^ slot_mask;
    for (int s = 0; s < sxfs_pkg::SLOTS; s++) begin
      act[s] = (q_job.kind == sxfs_pkg::CMD_DRAW) && (s < 2 || q_job.two_rows) &&
               ((s % 2 == 1) ? (|q_job.mask_hi) : (|q_job.mask_lo));
    end
  end

  assign out_free   = !out_valid_r || pop;
  assign rd_addr    = (job_r.kind == sxfs_pkg::CMD_READ) ? job_r.word_index : slot_addr;
  assign rd_inrange = ({1'b0, rd_addr} < 8'(STORE_WORDS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sxfs_pkg::BK_IDLE: begin
        if (!q_empty) state_nxt = sxfs_pkg::BK_SCAN;
      end
      sxfs_pkg::BK_SCAN: begin
        if (job_r.kind == sxfs_pkg::CMD_DRAW && pend_r != '0) begin
          state_nxt = sxfs_pkg::BK_MODIFY;
        end else begin
          state_nxt = sxfs_pkg::BK_DONE;
        end
      end
      sxfs_pkg::BK_MODIFY: begin
        state_nxt = (pend_nxt != '0) ? sxfs_pkg::BK_SCAN : sxfs_pkg::BK_DONE;
      end
      sxfs_pkg::BK_DONE: begin
        if (out_free) state_nxt = sxfs_pkg::BK_IDLE;
      end
      default: state_nxt = sxfs_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    clr_all  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      sxfs_pkg::BK_IDLE:   q_pop = !q_empty;
      sxfs_pkg::BK_SCAN: begin
        rd_en   = (job_r.kind == sxfs_pkg::CMD_READ) ||
                  (job_r.kind == sxfs_pkg::CMD_DRAW && pend_r != '0);
        clr_all = (job_r.kind == sxfs_pkg::CMD_CLEAR);
      end
      sxfs_pkg::BK_MODIFY: wr_en = 1'b1;
      sxfs_pkg::BK_DONE:   load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    hit_nxt  = hit_r;
    if (state_r == sxfs_pkg::BK_IDLE) begin
      pend_nxt = act;
      hit_nxt  = 1'b0;
    end else if (wr_en) begin
      pend_nxt = pend_r & ~(4'b0001 << slot);
      hit_nxt  = hit_r | (|(old_word & slot_mask));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sxfs_pkg::BK_IDLE;
      pend_r      <= '0;
      hit_r       <= 1'b0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (job_r.kind == sxfs_pkg::CMD_DRAW) acc_r <= job_r.last ? 1'b0 : (acc_r | hit_r);
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[slot_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[slot_addr[AW-1:0]] <= new_word;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
      rd_hit_r  <= valid_r[rd_addr[AW-1:0]] && rd_inrange;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sxfs_pkg::BK_IDLE && !q_empty) job_r <= q_job;
    if (load_out) begin
      out_coll_r <= (job_r.kind == sxfs_pkg::CMD_DRAW) && job_r.last && (acc_r | hit_r);
      out_word_r <= (job_r.kind == sxfs_pkg::CMD_READ && rd_hit_r) ? rd_data_r : '0;
    end
  end

  assign empty         = !out_valid_r;
  assign out_collision = out_coll_r;
  assign out_read_word = out_word_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sxfs_pkg::BK_DONE))
    else $error("result loaded outside of job completion");

  a_one_word_per_modify: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sxfs_pkg::BK_MODIFY) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("modify did not retire exactly one word");

  a_clear_flash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sxfs_pkg::BK_SCAN && job_r.kind == sxfs_pkg::CMD_CLEAR) |=> (valid_r == '0))
    else $error("clear left valid words");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sxfs_pkg::BK_MODIFY) |-> ({1'b0, slot_addr} < 8'(STORE_WORDS)))
    else $error("draw write outside frame store");

endmodule

`default_nettype wire

/* rtl/sprite_xor_frame_store.sv */
// ----------------------------------------------------------------------------
// sprite_xor_frame_store
// Monochrome XOR sprite frame store with clear, draw-row and word read.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time by the back
// end, which owns a single-port frame memory with registered read. A draw row
// reads, then XOR-writes, each touched word: one word for a row inside one
// word, two across a word boundary, up to four in doubling mode across a
// boundary; a fully clipped row touches no word. Clear drops the per-word valid
// flags at once, no sweep; read does one registered memory read. Reset needs no
// clearing pass. Each request yields exactly one result.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_xor_frame_store #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 64,
  parameter int SPRITE_ROWS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_start_x,
  input  wire logic [7:0]  in_start_y,
  input  wire logic [7:0]  in_row_bits,
  input  wire logic        in_row_last,
  input  wire logic [6:0]  in_word_index,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_collision,
  output logic [63:0]      out_read_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic hires_r, dbl_r, cfg_wr;
  sxfs_pkg::sxfs_cfg_t cfg;
  sxfs_pkg::reg_idx_t  reg_sel;
  sxfs_pkg::sxfs_job_t fq_job, qb_job;
  logic fq_push, q_full, q_empty, q_pop;

  assign pready  = 1'b1;
  assign reg_sel = sxfs_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hires_r <= 1'b0;
      dbl_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        sxfs_pkg::REG_HIRES:    hires_r <= pwdata[0];
        sxfs_pkg::REG_DOUBLING: dbl_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata    = {31'b0, (reg_sel == sxfs_pkg::REG_DOUBLING) ? dbl_r : hires_r};
  assign cfg.hires = hires_r;
  assign cfg.dbl   = dbl_r;

  sxfs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SPRITE_ROWS(SPRITE_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_row_bits  (in_row_bits),
    .in_row_last  (in_row_last),
    .in_word_index(in_word_index),
    .q_push       (fq_push),
    .q_job        (fq_job),
    .q_full       (q_full)
  );

  sxfs_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .din  (fq_job),
    .full (q_full),
    .pop  (q_pop),
    .dout (qb_job),
    .empty(q_empty)
  );

  sxfs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (qb_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_collision(out_collision),
    .out_read_word(out_read_word)
  );

endmodule

`default_nettype wire

/* sim/sprite_xor_frame_store_tb.sv */
// ----------------------------------------------------------------------------
// sprite_xor_frame_store_tb
// Self-checking testbench for the sprite XOR frame store.
// ----------------------------------------------------------------------------
// Requests (draw row, clear, read word, unused code) are queued by the stimulus
// process and sent by a clocked driver with random gaps. A clocked monitor
// predicts each accepted request against a local copy of the frame, row
// counter and collision flag, and compares every popped result with the oldest
// prediction. Frame size and pixel doubling are changed over APB between
// phases, with and without a following clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_xor_frame_store_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS = 128;
  localparam int MAX_SHOWN   = 40;

  // per-phase plan, phase 0 in the leftmost bit
  localparam bit [0:6] PLAN_HIRES = 7'b1100110;
  localparam bit [0:6] PLAN_DBL   = 7'b0110101;
  localparam bit [0:6] PLAN_WIPE  = 7'b1010100;

  typedef struct {
    sxfs_pkg::cmd_t cmd;
    logic [7:0]     sx;
    logic [7:0]     sy;
    logic [7:0]     bits;
    logic           last;
    logic [6:0]     widx;
  } sprite_req_t;

  typedef struct {
    logic        collision;
    logic [63:0] word;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_cmd;
  logic [7:0]  in_start_x;
  logic [7:0]  in_start_y;
  logic [7:0]  in_row_bits;
  logic        in_row_last;
  logic [6:0]  in_word_index;
  logic        empty;
  logic        pop;
  logic        out_collision;
  logic [63:0] out_read_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sprite_xor_frame_store i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_row_bits   (in_row_bits),
    .in_row_last   (in_row_last),
    .in_word_index (in_word_index),
    .empty         (empty),
    .pop           (pop),
    .out_collision (out_collision),
    .out_read_word (out_read_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // frame model
  logic [63:0]   pix_mem [STORE_WORDS];
  logic          sprite_hit;
  logic [3:0]    sprite_row;
  logic          cfg_hires;
  logic          cfg_dbl;

  sprite_req_t   req_backlog [$];
  frame_result_t results_due [$];

  bit            offering;
  bit            req_taken;
  bit            res_taken;
  bit            gap_on;
  int            send_gap;
  int            rcv_gap;
  int            hold_req;
  int            hold_left;
  int            err_count;
  int            n_draws;
  int            n_reads;
  int            n_hits;
  int            n_full_cycles;
  int            n_results;
  sprite_req_t   cur_req;
  sprite_req_t   seen_req;
  frame_result_t due;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("sprite_xor_frame_store test failed");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit flip_pixel(int unsigned px, int unsigned py, int unsigned wpr);
    int unsigned idx;
    bit was;
    idx = py * wpr + (px >> 6);
    if (idx >= STORE_WORDS) return 1'b0;
    was = pix_mem[idx][px & 63];
    pix_mem[idx][px & 63] = ~was;
    return was;
  endfunction

  function automatic frame_result_t frame_apply(sprite_req_t r);
    frame_result_t res;
    int unsigned wid, hgt, wpr, scl, lw, lh, xpos, y, x;
    bit hit;
    res.collision = 1'b0;
    res.word = '0;
    hit = 1'b0;
    case (r.cmd)
      sxfs_pkg::CMD_DRAW: begin
        wid = cfg_hires ? 128 : 64;
        hgt = cfg_hires ? 64 : 32;
        wpr = wid / 64;
        scl = cfg_dbl ? 2 : 1;
        lw = wid / scl;
        lh = hgt / scl;
        xpos = r.sx % lw;
        y = r.sy % lh + sprite_row;
        if (y < lh) begin
          for (int k = 0; k < 8; k++) begin
            x = xpos + k;
            if (r.bits[7 - k] && x < lw) begin
              if (scl == 2) begin
                hit |= flip_pixel(2 * x, 2 * y, wpr);
                hit |= flip_pixel(2 * x + 1, 2 * y, wpr);
                hit |= flip_pixel(2 * x, 2 * y + 1, wpr);
                hit |= flip_pixel(2 * x + 1, 2 * y + 1, wpr);
              end else begin
                hit |= flip_pixel(x, y, wpr);
              end
            end
          end
        end
        sprite_hit |= hit;
        if (r.last) begin
          res.collision = sprite_hit;
          sprite_hit = 1'b0;
          sprite_row = '0;
        end else begin
          sprite_row = sprite_row + 4'd1;
        end
      end
      sxfs_pkg::CMD_CLEAR: begin
        foreach (pix_mem[i]) pix_mem[i] = '0;
      end
      sxfs_pkg::CMD_READ: begin
        res.word = pix_mem[r.widx];
      end
      default: ;
    endcase
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken) offering = 1'b0;
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          in_cmd <= cur_req.cmd;
          in_start_x <= cur_req.sx;
          in_start_y <= cur_req.sy;
          in_row_bits <= cur_req.bits;
          in_row_last <= cur_req.last;
          in_word_index <= cur_req.widx;
          offering = 1'b1;
          send_gap = pick_gap();
        end
      end
      push <= offering;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (res_taken) rcv_gap = pick_gap();
        if (rcv_gap > 0) begin
          rcv_gap--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // monitor: predict accepted requests, check popped results
  always @(posedge clk) begin
    req_taken = rst_n && push && !full;
    res_taken = rst_n && pop && !empty;
    if (rst_n && push && full) n_full_cycles++;
    if (req_taken) begin
      seen_req.cmd = sxfs_pkg::cmd_t'(in_cmd);
      seen_req.sx = in_start_x;
      seen_req.sy = in_start_y;
      seen_req.bits = in_row_bits;
      seen_req.last = in_row_last;
      seen_req.widx = in_word_index;
      if (seen_req.cmd == sxfs_pkg::CMD_DRAW) n_draws++;
      if (seen_req.cmd == sxfs_pkg::CMD_READ) n_reads++;
      results_due.push_back(frame_apply(seen_req));
    end
    if (res_taken) begin
      n_results++;
      if (results_due.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        due = results_due.pop_front();
        if (due.collision) n_hits++;
        if (out_collision !== due.collision)
          flag_mismatch($sformatf("collision %b, want %b", out_collision, due.collision));
        if (out_read_word !== due.word)
          flag_mismatch($sformatf("read_word %h, want %h", out_read_word, due.word));
      end
    end
  end

  task automatic add_req(input sxfs_pkg::cmd_t c, input logic [7:0] sx,
                         input logic [7:0] sy, input logic [7:0] bits, input logic last,
                         input logic [6:0] widx);
    sprite_req_t r;
    r.cmd = c;
    r.sx = sx;
    r.sy = sy;
    r.bits = bits;
    r.last = last;
    r.widx = widx;
    req_backlog.push_back(r);
  endtask

  task automatic cfg_access(input bit wr, input sxfs_pkg::reg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(input sxfs_pkg::reg_idx_t idx, input bit v);
    logic [31:0] rd;
    cfg_access(1'b1, idx, {31'd0, v}, rd);
    if (idx == sxfs_pkg::REG_HIRES) cfg_hires = v;
    else cfg_dbl = v;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== {31'd0, v})
      flag_mismatch($sformatf("register %s reads %h, want %0d", idx.name(), rd, v));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (req_backlog.size() != 0 || offering || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic add_random_traffic(input int n);
    int added, sel, rows;
    logic [7:0] sx, sy, last_sx, last_sy;
    sprite_req_t r;
    added = 0;
    last_sx = 8'($urandom_range(0, 255));
    last_sy = 8'($urandom_range(0, 255));
    while (added < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        rows = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        if ($urandom_range(0, 2) == 0) begin
          sx = last_sx + 8'($urandom_range(0, 3));
          sy = last_sy + 8'($urandom_range(0, 2));
        end else begin
          sx = 8'($urandom_range(0, 255));
          sy = 8'($urandom_range(0, 255));
        end
        last_sx = sx;
        last_sy = sy;
        for (int k = 0; k < rows; k++)
          add_req(sxfs_pkg::CMD_DRAW, sx, sy, 8'($urandom_range(0, 255)), k == rows - 1,
                  7'($urandom_range(0, 127)));
        added += rows;
      end else begin
        if (sel < 85) begin
          r.cmd = sxfs_pkg::CMD_READ;
        end else if (sel < 88) begin
          r.cmd = sxfs_pkg::CMD_CLEAR;
        end else if (sel < 90) begin
          r.cmd = sxfs_pkg::CMD_NONE;
        end else begin
          r.cmd = sxfs_pkg::cmd_t'($urandom_range(0, 3));
        end
        r.sx = 8'($urandom_range(0, 255));
        r.sy = 8'($urandom_range(0, 255));
        r.bits = 8'($urandom_range(0, 255));
        r.last = 1'($urandom_range(0, 1));
        if (r.cmd == sxfs_pkg::CMD_READ && $urandom_range(0, 1) == 0)
          r.widx = 7'($urandom_range(0, cfg_hires ? 127 : 31));
        else
          r.widx = 7'($urandom_range(0, 127));
        req_backlog.push_back(r);
        added++;
      end
    end
  endtask

  initial begin
    bit h, d, w;

    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_cmd = sxfs_pkg::CMD_NONE;
    in_start_x = '0;
    in_start_y = '0;
    in_row_bits = '0;
    in_row_last = 1'b0;
    in_word_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    sprite_hit = 1'b0;
    sprite_row = '0;
    cfg_hires = 1'b0;
    cfg_dbl = 1'b0;
    gap_on = 1'b1;
    hold_req = 0;
    hold_left = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, wrap, clip, collision, clear inside a sprite
    add_req(sxfs_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_READ, 8'hff, 8'hff, 8'hff, 1'b1, 7'd127);
    add_req(sxfs_pkg::CMD_DRAW, 8'd0, 8'd0, 8'hff, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd0, 8'd0, 8'hff, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd255, 8'd255, 8'h81, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0, 7'd31);
    add_req(sxfs_pkg::CMD_DRAW, 8'd60, 8'd11, 8'hff, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd60, 8'd10, 8'hff, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd60, 8'd10, 8'hff, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd60, 8'd10, 8'h00, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0, 7'd11);
    add_req(sxfs_pkg::CMD_DRAW, 8'd3, 8'd30, 8'h3c, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd3, 8'd30, 8'hc3, 1'b0, 7'd0);
    add_req(sxfs_pkg::CMD_DRAW, 8'd3, 8'd30, 8'hff, 1'b1, 7'd0);
    add_req(sxfs_pkg::CMD_NONE, 8'hff, 8'hff, 8'hff, 1'b1, 7'd127);
    add_req(sxfs_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0, 7'd30);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p < 7) begin
        h = PLAN_HIRES[p];
        d = PLAN_DBL[p];
        w = PLAN_WIPE[p];
      end else begin
        h = 1'($urandom_range(0, 1));
        d = 1'($urandom_range(0, 1));
        w = 1'($urandom_range(0, 1));
      end
      cfg_write(sxfs_pkg::REG_HIRES, h);
      cfg_write(sxfs_pkg::REG_DOUBLING, d);
      gap_on = !(p == 3 || p == 5);
      if (p == 3) hold_req = 300;
      if (w) add_req(sxfs_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0);
      add_random_traffic(180);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d draw rows, %0d word reads, %0d reported collisions, %0d results.",
             n_draws, n_reads, n_hits, n_results);
    $display("Both frame sizes with and without doubling; input stalled on %0d cycles.",
             n_full_cycles);
    if (err_count == 0) begin
      $display("sprite_xor_frame_store test passed");
    end else begin
      $display("sprite_xor_frame_store test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/sxfs_pkg.sv
rtl/sxfs_front.sv
rtl/sxfs_queue.sv
rtl/sxfs_back.sv
rtl/sprite_xor_frame_store.sv
sim/sprite_xor_frame_store_tb.sv
